>>> rtl/core/urla_pkg.sv
// shared constants for the uart receive line assembler
package urla_pkg;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
  localparam int unsigned BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] TRIGGER_RESET = 8'd10;

endpackage

>>> rtl/core/uart_rx_line_assembler.sv
// uart receive line assembler: stores received bytes and releases a line on the trigger byte
//
// An ordinary byte is accepted and written into the 64-entry line ram. The trigger
// byte releases entries 0 up to but not including the write index, stopping before
// the first zero byte, one item per cycle from the single ram read port while the output
// is not stalled; a line with no bytes or a zero first byte comes out as one empty-line
// item. While a line is being released the input is held off; output back-pressure
// stalls the release. The line ram needs no clearing after reset. The trigger value
// resets to a line feed; the user is to write it on the cfg port only while the block is
// idle, and the block itself does not enforce this.
module uart_rx_line_assembler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [urla_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [urla_pkg::BYTE_W-1:0] out_line_byte,
  output logic                       out_last,
  output logic                       out_empty_line,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [urla_pkg::BYTE_W-1:0] cfg_trigger_char
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_FLUSH = 4'b0100,
    S_EMPTY = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [urla_pkg::BYTE_W-1:0]   trig_r;
  logic [urla_pkg::IDX_W-1:0]    widx_r, widx_nxt;
  logic [urla_pkg::IDX_W-1:0]    lim_r, lim_nxt;
  logic [urla_pkg::IDX_W-1:0]    cur_r, cur_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  logic [urla_pkg::BYTE_W-1:0]   pend_byte_r, pend_byte_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [urla_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_empty_r, out_empty_nxt;

  logic                          in_acc;
  logic                          is_trig;
  logic                          out_free;
  logic [urla_pkg::IDX_W:0]      cur_inc;
  logic                          ram_we;
  logic                          ram_re;
  logic [urla_pkg::IDX_W-1:0]    ram_raddr;
  logic [urla_pkg::BYTE_W-1:0]   ram_rdata;

  urla_ram #(
    .WIDTH(urla_pkg::BYTE_W),
    .DEPTH(urla_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx_r),
    .wdata(in_rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_trig   = (in_rx_byte == trig_r);
  assign out_free  = !out_valid_r || out_ready;
  assign cur_inc   = {1'b0, cur_r} + {{urla_pkg::IDX_W{1'b0}}, 1'b1};
  assign ram_we    = in_acc && !is_trig;

  always_comb begin
    state_nxt      = state_r;
    widx_nxt       = widx_r;
    lim_nxt        = lim_r;
    cur_nxt        = cur_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    ram_re         = 1'b0;
    ram_raddr      = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_trig) begin
            if (widx_r == urla_pkg::IDX_W'(urla_pkg::LINE_DEPTH - 1)) begin
              widx_nxt = '0;
            end else begin
              widx_nxt = widx_r + urla_pkg::IDX_W'(1);
            end
          end else begin
            widx_nxt       = '0;
            lim_nxt        = widx_r;
            cur_nxt        = '0;
            pend_valid_nxt = 1'b0;
            if (widx_r == '0) begin
              state_nxt = S_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        // ram_rdata holds entry cur_r
        if (ram_rdata == '0) begin
          state_nxt = pend_valid_r ? S_FLUSH : S_EMPTY;
        end else if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = pend_byte_r;
            out_last_nxt  = 1'b0;
            out_empty_nxt = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_byte_nxt  = ram_rdata;
          if (cur_inc == {1'b0, lim_r}) begin
            state_nxt = S_FLUSH;
          end else begin
            cur_nxt   = cur_inc[urla_pkg::IDX_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = cur_inc[urla_pkg::IDX_W-1:0];
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = pend_byte_r;
          out_last_nxt   = 1'b1;
          out_empty_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      trig_r       <= urla_pkg::TRIGGER_RESET;
      widx_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      widx_r       <= widx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        trig_r <= cfg_trigger_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    cur_r       <= cur_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_line_byte  = out_byte_r;
  assign out_last       = out_last_r;
  assign out_empty_line = out_empty_r;

  // a trigger item always starts a release
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_rx_byte == trig_r)) |=> !in_ready)
    else $error("trigger item did not start a line release");

  // the final item of a line always has a byte waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> pend_valid_r)
    else $error("flush without a pending byte");

  // reads stay below the released length
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (cur_r < lim_r))
    else $error("line read past the write index");

  // an empty-line item is a lone final item carrying zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_line) |-> (out_last && (out_line_byte == '0)))
    else $error("malformed empty-line item");

endmodule

>>> rtl/core/urla_ram.sv
// generic single-write, single-read ram with registered read data
module urla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> bench/urla_line_tracker.sv
// line assembler checker: follows bytes and trigger writes, predicts released lines, checks output
`timescale 1ns / 1ps
module urla_line_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [urla_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [urla_pkg::BYTE_W-1:0] out_line_byte,
  input  logic                        out_last,
  input  logic                        out_empty_line,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [urla_pkg::BYTE_W-1:0] cfg_trigger_char,
  output int                          fail_count,
  output int                          pending_chars,
  output int                          lines_released,
  output int                          chars_seen
);

  typedef struct packed {
    logic [urla_pkg::BYTE_W-1:0] ch;
    logic                        last;
    logic                        empty;
  } line_char_t;

  logic [urla_pkg::BYTE_W-1:0] line_mem [urla_pkg::LINE_DEPTH];
  logic [urla_pkg::IDX_W-1:0]  wr_idx;
  logic [urla_pkg::BYTE_W-1:0] trig;
  line_char_t                  chars_due [$];
  int                          fails;
  int                          lines;
  int                          seen;

  // store a byte, or on the trigger queue the line up to the first zero
  task automatic take_rx_byte(input logic [urla_pkg::BYTE_W-1:0] b);
    int         len;
    line_char_t item;
    len = 0;
    if (b != trig) begin
      line_mem[wr_idx] = b;
      if (int'(wr_idx) == urla_pkg::LINE_DEPTH - 1) wr_idx = '0;
      else wr_idx = wr_idx + 1'b1;
    end else begin
      while (len < int'(wr_idx) && line_mem[urla_pkg::IDX_W'(len)] != '0) len++;
      wr_idx = '0;
      lines++;
      if (len == 0) begin
        item.ch    = '0;
        item.last  = 1'b1;
        item.empty = 1'b1;
        chars_due.push_back(item);
      end else begin
        for (int i = 0; i < len; i++) begin
          item.ch    = line_mem[urla_pkg::IDX_W'(i)];
          item.last  = (i + 1 == len);
          item.empty = 1'b0;
          chars_due.push_back(item);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    line_char_t want;
    if (!rst_n) begin
      wr_idx = '0;
      trig   = urla_pkg::TRIGGER_RESET;
      chars_due.delete();
      fails  = 0;
      lines  = 0;
      seen   = 0;
    end else begin
      if (cfg_valid && cfg_ready) trig = cfg_trigger_char;
      if (in_valid && in_ready) take_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        seen++;
        if (chars_due.size() == 0) begin
          $display("%0t: line item with none expected: expected nothing, %s %02h %0d %0d",
                   $time, "got byte/last/empty", out_line_byte, out_last, out_empty_line);
          fails++;
        end else begin
          want = chars_due.pop_front();
          check_field("line_byte", want.ch, out_line_byte);
          check_field("last", want.last, out_last);
          check_field("empty_line", want.empty, out_empty_line);
        end
      end
    end
    fail_count     <= fails;
    pending_chars  <= chars_due.size();
    lines_released <= lines;
    chars_seen     <= seen;
  end

endmodule

>>> bench/uart_rx_line_assembler_tb.sv
// testbench top for the uart receive line assembler: stimulus, idling and verdict
`timescale 1ns / 1ps
module uart_rx_line_assembler_tb;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int ITEM_TARGET    = 110;

  typedef enum {SEQ_SHORT, SEQ_ZERO, SEQ_NOISE, SEQ_MEDIUM, SEQ_FULL} seq_kind_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_ready;
  logic [urla_pkg::BYTE_W-1:0] in_rx_byte       = '0;
  logic                        out_valid;
  logic                        out_ready        = 1'b0;
  logic [urla_pkg::BYTE_W-1:0] out_line_byte;
  logic                        out_last;
  logic                        out_empty_line;
  logic                        cfg_valid        = 1'b0;
  logic                        cfg_ready;
  logic [urla_pkg::BYTE_W-1:0] cfg_trigger_char = '0;

  int                          fail_count;
  int                          pending_chars;
  int                          lines_released;
  int                          chars_seen;

  bit                          quiet       = 1'b0;
  logic [urla_pkg::BYTE_W-1:0] trig_now    = urla_pkg::TRIGGER_RESET;
  int                          items_sent  = 0;
  int                          settings    = 0;
  int                          out_hold    = 0;
  int                          idle_cycles = 0;

  always #6 clk = ~clk;

  uart_rx_line_assembler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_byte    (out_line_byte),
    .out_last         (out_last),
    .out_empty_line   (out_empty_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_trigger_char (cfg_trigger_char)
  );

  urla_line_tracker i_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_byte    (out_line_byte),
    .out_last         (out_last),
    .out_empty_line   (out_empty_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_trigger_char (cfg_trigger_char),
    .fail_count       (fail_count),
    .pending_chars    (pending_chars),
    .lines_released   (lines_released),
    .chars_seen       (chars_seen)
  );

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  // line content: never the trigger, zero only when asked for
  function automatic logic [urla_pkg::BYTE_W-1:0] line_char(input bit allow_zero);
    logic [urla_pkg::BYTE_W-1:0] c;
    if (allow_zero && trig_now != '0 && $urandom_range(0, 7) == 0) return '0;
    do c = urla_pkg::BYTE_W'($urandom_range(0, 255)); while (c == trig_now || c == '0);
    return c;
  endfunction

  // receiver side stall: a hold-off drawn for each accepted line item
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && out_ready) begin
      gap = draw_gap();
      out_hold  <= gap;
      out_ready <= (gap == 0);
    end else if (!out_ready) begin
      if (out_hold <= 1) begin
        out_ready <= 1'b1;
        out_hold  <= 0;
      end else begin
        out_hold <= out_hold - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("uart_rx_line_assembler regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [urla_pkg::BYTE_W-1:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_line(input int len, input bit allow_zero);
    for (int i = 0; i < len; i++) send_byte(line_char(allow_zero));
    send_byte(trig_now);
  endtask

  // all lines drained, then a wait for the block to settle back to idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_trigger(input logic [urla_pkg::BYTE_W-1:0] v);
    wait_idle();
    cfg_valid        <= 1'b1;
    cfg_trigger_char <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trig_now = v;
    settings++;
  endtask

  initial begin
    int                          phase;
    int                          nseq;
    seq_kind_t                   kind;
    logic [urla_pkg::BYTE_W-1:0] v;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trigger straight after reset gives an empty line
    send_byte(urla_pkg::TRIGGER_RESET);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(urla_pkg::TRIGGER_RESET);
    // zero in the middle cuts the line short
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h42);
    send_byte(urla_pkg::TRIGGER_RESET);
    // zero as first byte releases an empty line
    send_byte(8'h00);
    send_byte(8'h43);
    send_byte(urla_pkg::TRIGGER_RESET);

    // zero as trigger: line feed is stored as ordinary data
    set_trigger(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h0A);
    send_byte(8'h00);
    send_byte(8'h00);

    set_trigger(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: v = 8'h0A;
        1: v = 8'h00;
        2: v = 8'hFF;
        default: v = urla_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
      set_trigger(v);
      quiet = (phase % 3 == 2);
      nseq = $urandom_range(3, 6);
      for (int s = 0; s < nseq && items_sent < ITEM_TARGET; s++) begin
        if (phase == 0 && s == 0) begin
          kind = SEQ_FULL;
        end else begin
          case ($urandom_range(0, 9))
            5, 6:    kind = SEQ_ZERO;
            7:       kind = SEQ_NOISE;
            8:       kind = SEQ_MEDIUM;
            default: kind = SEQ_SHORT;
          endcase
        end
        case (kind)
          SEQ_SHORT:  send_line($urandom_range(0, 10), 1'b0);
          SEQ_ZERO:   send_line($urandom_range(1, 12), 1'b1);
          SEQ_MEDIUM: send_line($urandom_range(11, 30), 1'b0);
          SEQ_FULL:   send_line(urla_pkg::LINE_DEPTH - 1, 1'b0);
          default: begin
            repeat ($urandom_range(1, 6)) send_byte(urla_pkg::BYTE_W'($urandom_range(0, 255)));
          end
        endcase
      end
      phase++;
    end

    quiet = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);

    $display("sent %0d rx bytes under %0d trigger settings, a full-length line included",
             items_sent, settings);
    $display("%0d lines released as %0d line items", lines_released, chars_seen);
    if (fail_count == 0 && pending_chars == 0) begin
      $display("uart_rx_line_assembler regression: pass");
    end else begin
      $display("uart_rx_line_assembler regression: fail");
    end
    $finish;
  end

endmodule
